// File: src/kes_pkg.sv
// Shared types and codes for the keypad event scanner.
package kes_pkg;

    // Number of port bytes read back in one scan (one per driven row).
    localparam int unsigned NUM_PORTS  = 4;
    localparam int unsigned PORT_W     = 8;
    localparam int unsigned KEY_W      = 5;
    localparam int unsigned INDEX_W    = 4;
    localparam int unsigned STAMP_W    = 32;

    // Default geometry of the full keypad layout.
    localparam int unsigned KP_ROWS    = 4;
    localparam int unsigned KP_COLS    = 4;

    // Code meaning that no key is down.
    localparam logic [KEY_W-1:0] NO_KEY = 5'd31;

    // Keypad layout codes held in the layout register.
    localparam logic [1:0] LAYOUT_ROW  = 2'd0;
    localparam logic [1:0] LAYOUT_4X3  = 2'd1;
    localparam logic [1:0] LAYOUT_FULL = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_LAYOUT  = 2'd0;
    localparam logic [1:0] REG_HOLD    = 2'd1;

    localparam logic [STAMP_W-1:0] HOLD_RESET = 32'd1000;

    typedef logic [NUM_PORTS-1:0][PORT_W-1:0] t_ports;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2,
        EV_LONG    = 2'd3
    } t_key_event;

    typedef struct packed {
        t_key_event          key_event;
        logic [INDEX_W-1:0]  key_index;
        logic                key_down;
    } t_result;

endpackage

// File: src/kes_key_find.sv
// Decodes one scan of port bytes into the index of the pressed key.
module kes_key_find
    import kes_pkg::*;
#(
    parameter int unsigned ROWS = KP_ROWS,
    parameter int unsigned COLS = KP_COLS
)
(
    input  logic [1:0]       i_layout,
    input  t_ports           i_ports,
    output logic [KEY_W-1:0] o_key
);

    // Geometry of the full layout; rows past the four port bytes are never scanned.
    localparam int unsigned FULL_ROWS = (ROWS > NUM_PORTS) ? NUM_PORTS : ROWS;
    localparam int unsigned FULL_COLS = (COLS > 4) ? 4 : COLS;
    localparam int unsigned COL_BASE  = 4;

    logic [KEY_W-1:0] key;

    // Later rows and columns overwrite earlier ones, so the last key found wins.
    always_comb begin
        key = NO_KEY;
        case (i_layout)
            LAYOUT_ROW: begin
                for (int c = 0; c < 4; c++) begin
                    if (!i_ports[0][c]) key = KEY_W'(c);
                end
            end
            LAYOUT_4X3: begin
                for (int r = 0; r < NUM_PORTS; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        if (!i_ports[r][COL_BASE+c]) key = KEY_W'((r * 3 + c) % 16);
                    end
                end
            end
            LAYOUT_FULL: begin
                for (int r = 0; r < FULL_ROWS; r++) begin
                    for (int c = 0; c < FULL_COLS; c++) begin
                        if (!i_ports[r][COL_BASE+c]) begin
                            key = KEY_W'((r * FULL_COLS + c) % 16);
                        end
                    end
                end
            end
            default: key = NO_KEY;
        endcase
    end

    assign o_key = key;

endmodule

// File: src/kes_event_track.sv
// Press, release and long-press tracking state with event selection.
module kes_event_track
    import kes_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [STAMP_W-1:0] i_now_ms,
    input  logic [STAMP_W-1:0] i_hold_ms,
    output t_result            o_result
);

    logic [KEY_W-1:0]   r_prev_key, n_prev_key;
    logic [KEY_W-1:0]   r_armed_key, n_armed_key;
    logic [STAMP_W-1:0] r_press_stamp, n_press_stamp;

    logic               key_valid;
    logic               is_press;
    logic               is_release;
    logic               is_long;
    logic [STAMP_W-1:0] elapsed;

    assign key_valid  = (i_key != NO_KEY);
    assign elapsed    = i_now_ms - r_press_stamp;
    assign is_press   = key_valid && (i_key != r_prev_key);
    assign is_release = !key_valid && (r_prev_key != NO_KEY) && (r_armed_key != NO_KEY);
    // A fresh press restarts the hold timer, so it can never be long in the same scan.
    assign is_long    = key_valid && !is_press && (r_armed_key != NO_KEY)
                        && (elapsed > i_hold_ms);

    always_comb begin
        n_prev_key    = i_key;
        n_armed_key   = r_armed_key;
        n_press_stamp = r_press_stamp;
        o_result.key_event = EV_NONE;
        o_result.key_index = '0;
        o_result.key_down  = key_valid;
        if (is_press) begin
            o_result.key_event = EV_PRESS;
            o_result.key_index = i_key[INDEX_W-1:0];
            n_armed_key        = i_key;
            n_press_stamp      = i_now_ms;
        end
        if (is_release) begin
            o_result.key_event = EV_RELEASE;
            o_result.key_index = r_prev_key[INDEX_W-1:0];
        end
        if (is_long) begin
            o_result.key_event = EV_LONG;
            o_result.key_index = i_key[INDEX_W-1:0];
            n_armed_key        = NO_KEY;
            n_press_stamp      = i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_key    <= NO_KEY;
            r_armed_key   <= NO_KEY;
            r_press_stamp <= '0;
        end else if (i_advance) begin
            r_prev_key    <= n_prev_key;
            r_armed_key   <= n_armed_key;
            r_press_stamp <= n_press_stamp;
        end
    end

endmodule

// File: src/matrix_keypad_event_scanner_unit.sv
// Top level of the matrix keypad event scanner: handshakes, registers and result stage.
//
// Each input transaction carries one complete keypad scan (the four row port
// bytes, active low, and a millisecond timestamp) and yields exactly one
// result transaction with the event code (none, press, release or long
// press), the reported key index and a key-down flag. The unit takes a new
// scan in every clock cycle while its results are taken; a scan passes
// through the input register and then the result register, which drives
// the outputs. Key decode and event selection are a single combinational
// pass between the two, and the tracking state is updated as each scan
// leaves the input register. When the result register is full and not
// being taken, a scan already held in the input register stays there and
// the unit stops accepting. Layout and hold time are written through the
// configuration channel, which is always ready, and should only be changed
// while no scan is in flight. There is no clearing pass after reset.
module matrix_keypad_event_scanner_unit
    import kes_pkg::*;
#(
    parameter int unsigned ROWS = KP_ROWS,
    parameter int unsigned COLS = KP_COLS
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [STAMP_W-1:0] i_cfg_data,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [PORT_W-1:0]  i_row0_read,
    input  logic [PORT_W-1:0]  i_row1_read,
    input  logic [PORT_W-1:0]  i_row2_read,
    input  logic [PORT_W-1:0]  i_row3_read,
    input  logic [STAMP_W-1:0] i_now_ms,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_key_event,
    output logic [INDEX_W-1:0] o_key_index,
    output logic               o_key_down
);

    // Configuration registers.
    logic [1:0]         r_layout;
    logic [STAMP_W-1:0] r_hold_ms;

    // Input stage.
    logic               r_s1_valid;
    t_ports             r_ports;
    logic [STAMP_W-1:0] r_now_ms;

    // Result stage.
    logic               r_out_valid;
    t_result            r_result;

    logic               out_free;
    logic               advance;
    logic               in_take;
    logic [KEY_W-1:0]   key;
    t_result            result;

    // The result register can load when empty or when its transaction leaves now.
    assign out_free    = !r_out_valid || i_out_ready;
    assign advance     = r_s1_valid && out_free;
    assign o_in_ready  = !r_s1_valid || out_free;
    assign in_take     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout  <= LAYOUT_FULL;
            r_hold_ms <= HOLD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LAYOUT: r_layout  <= i_cfg_data[1:0];
                REG_HOLD:   r_hold_ms <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ports  <= {i_row3_read, i_row2_read, i_row1_read, i_row0_read};
            r_now_ms <= i_now_ms;
        end
    end

    kes_key_find #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_key_find (
        .i_layout (r_layout),
        .i_ports  (r_ports),
        .o_key    (key)
    );

    // Tracking state moves on exactly once per scan, as it enters the result register.
    kes_event_track u_event_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_key     (key),
        .i_now_ms  (r_now_ms),
        .i_hold_ms (r_hold_ms),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_event = r_result.key_event;
    assign o_key_index = r_result.key_index;
    assign o_key_down  = r_result.key_down;

endmodule
